// ===== rtl/riot_pkg.sv =====
`default_nettype none

package riot_pkg;

   // Transaction kinds carried on the request channel.
   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_IDLE  = 2'd3
   } mode_type;

   // Register select, taken from address bits 2..0.
   localparam logic [2:0] SEL_PORT_A  = 3'd0;
   localparam logic [2:0] SEL_DDR_A   = 3'd1;
   localparam logic [2:0] SEL_PORT_B  = 3'd2;
   localparam logic [2:0] SEL_DDR_B   = 3'd3;
   localparam logic [2:0] SEL_TIMER_0 = 3'd4;
   localparam logic [2:0] SEL_TIMER_2 = 3'd6;
   localparam logic [2:0] SEL_STATUS  = 3'd7;

   // Address bit that carries the interrupt enable on timer accesses.
   localparam int IRQ_EN_BIT = 3;

   localparam int PRESCALE_W = 10;

   localparam logic [7:0] READ_IDLE    = 8'hff;
   localparam logic [7:0] STATUS_FLAG  = 8'h80;
   localparam logic [7:0] STATUS_CLEAR = 8'h00;

   typedef enum logic [1:0] {
      DIV_1    = 2'd0,
      DIV_8    = 2'd1,
      DIV_64   = 2'd2,
      DIV_1024 = 2'd3
   } prescale_type;

   // Last prescaler count before the interval counter steps.
   function automatic logic [PRESCALE_W-1:0] prescale_last(input prescale_type sel);
      logic [PRESCALE_W-1:0] last;
      case (sel)
         DIV_1:    last = PRESCALE_W'(0);
         DIV_8:    last = PRESCALE_W'(7);
         DIV_64:   last = PRESCALE_W'(63);
         DIV_1024: last = PRESCALE_W'(1023);
         default:  last = PRESCALE_W'(0);
      endcase
      return last;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/riot_ports_and_interval_timer.sv =====
`default_nettype none

// Two 8-bit I/O ports with direction registers and an 8-bit interval timer.
// Each request transaction is a bus read, a bus write, or one timer tick (mode 3 is an
// idle transaction), and each produces exactly one response transaction carrying the read
// data (0xFF on anything but a read), both output latches, the port write strobes and
// the timer interrupt pulse. Port reads return the pin level on input bits and the latch on
// output bits. A write to offsets 4..7 starts the timer with the written count, a divide
// ratio of 1, 8, 64 or 1024 from address bits 1..0, and the interrupt enable from address
// bit 3; the timer then expires every ratio*(count+1) ticks. Reading the status register
// (offset 7) returns the expiry flag in bit 7 and clears it. Offsets 8..15 mirror 0..7.
// Throughput is one transaction per clock cycle while the response is not stalled. A
// transaction is held in the input register, then in the response register that drives
// the response port; the register update and response computation are combinational
// between those two registers. When the response is stalled, the input register still
// takes one more transaction before req_ready drops.
module riot_ports_and_interval_timer
   import riot_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [3:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_port_a_pins,
   input  wire logic [7:0] req_port_b_pins,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic [7:0]      rsp_port_a_drive,
   output logic [7:0]      rsp_port_b_drive,
   output logic            rsp_port_a_strobe,
   output logic            rsp_port_b_strobe,
   output logic            rsp_irq_pulse
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   mode_type   in_mode_ff;
   logic [3:0] in_address_ff;
   logic [7:0] in_write_data_ff;
   logic [7:0] in_pins_a_ff;
   logic [7:0] in_pins_b_ff;

   // Block state.
   logic [7:0]            out_latch_a_ff, out_latch_a_in;
   logic [7:0]            direction_a_ff, direction_a_in;
   logic [7:0]            out_latch_b_ff, out_latch_b_in;
   logic [7:0]            direction_b_ff, direction_b_in;
   logic                  irq_enable_ff, irq_enable_in;
   logic                  expired_flag_ff, expired_flag_in;
   logic                  timer_running_ff, timer_running_in;
   logic [7:0]            interval_count_ff, interval_count_in;
   logic [7:0]            reload_value_ff, reload_value_in;
   prescale_type          prescale_select_ff, prescale_select_in;
   logic [PRESCALE_W-1:0] prescale_count_ff, prescale_count_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff, rsp_read_data_in;
   logic [7:0] rsp_drive_a_ff;
   logic [7:0] rsp_drive_b_ff;
   logic       rsp_strobe_a_ff, rsp_strobe_a_in;
   logic       rsp_strobe_b_ff, rsp_strobe_b_in;
   logic       rsp_irq_ff, rsp_irq_in;

   logic       advance;
   logic       req_take;
   logic [2:0] sel;
   logic       addr_irq_en;

   // The input register hands its transaction on whenever the response slot is
   // empty or being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign sel         = in_address_ff[2:0];
   assign addr_irq_en = in_address_ff[IRQ_EN_BIT];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Register file and timer update for the transaction in the input register.
   always_comb begin
      out_latch_a_in     = out_latch_a_ff;
      direction_a_in     = direction_a_ff;
      out_latch_b_in     = out_latch_b_ff;
      direction_b_in     = direction_b_ff;
      irq_enable_in      = irq_enable_ff;
      expired_flag_in    = expired_flag_ff;
      timer_running_in   = timer_running_ff;
      interval_count_in  = interval_count_ff;
      reload_value_in    = reload_value_ff;
      prescale_select_in = prescale_select_ff;
      prescale_count_in  = prescale_count_ff;
      rsp_read_data_in   = READ_IDLE;
      rsp_strobe_a_in    = 1'b0;
      rsp_strobe_b_in    = 1'b0;
      rsp_irq_in         = 1'b0;

      case (in_mode_ff)
         MODE_READ: begin
            case (sel) inside
               SEL_PORT_A: begin
                  rsp_read_data_in = (in_pins_a_ff & ~direction_a_ff) |
                                     (out_latch_a_ff & direction_a_ff);
               end
               SEL_DDR_A: begin
                  rsp_read_data_in = direction_a_ff;
               end
               SEL_PORT_B: begin
                  rsp_read_data_in = (in_pins_b_ff & ~direction_b_ff) |
                                     (out_latch_b_ff & direction_b_ff);
               end
               SEL_DDR_B: begin
                  rsp_read_data_in = direction_b_ff;
               end
               [SEL_TIMER_0:SEL_TIMER_2]: begin
                  // Timer reads also update the interrupt enable.
                  rsp_read_data_in = interval_count_ff;
                  irq_enable_in    = addr_irq_en;
               end
               SEL_STATUS: begin
                  // Reading the status clears the expiry flag.
                  rsp_read_data_in = expired_flag_ff ? STATUS_FLAG : STATUS_CLEAR;
                  expired_flag_in  = 1'b0;
                  irq_enable_in    = addr_irq_en;
               end
               default: begin
                  rsp_read_data_in = READ_IDLE;
               end
            endcase
         end

         MODE_WRITE: begin
            case (sel) inside
               SEL_PORT_A: begin
                  out_latch_a_in  = in_write_data_ff;
                  rsp_strobe_a_in = 1'b1;
               end
               SEL_DDR_A: begin
                  direction_a_in = in_write_data_ff;
               end
               SEL_PORT_B: begin
                  out_latch_b_in  = in_write_data_ff;
                  rsp_strobe_b_in = 1'b1;
               end
               SEL_DDR_B: begin
                  direction_b_in = in_write_data_ff;
               end
               [SEL_TIMER_0:SEL_STATUS]: begin
                  // Timer start: load count and ratio, restart the prescaler.
                  expired_flag_in    = 1'b0;
                  irq_enable_in      = addr_irq_en;
                  reload_value_in    = in_write_data_ff;
                  interval_count_in  = in_write_data_ff;
                  prescale_select_in = prescale_type'(sel[1:0]);
                  prescale_count_in  = '0;
                  timer_running_in   = 1'b1;
               end
               default: begin
                  rsp_strobe_a_in = 1'b0;
               end
            endcase
         end

         MODE_TICK: begin
            if (timer_running_ff) begin
               if (prescale_count_ff != prescale_last(prescale_select_ff)) begin
                  prescale_count_in = prescale_count_ff + PRESCALE_W'(1);
               end else begin
                  prescale_count_in = '0;
                  if (interval_count_ff != 8'd0) begin
                     interval_count_in = interval_count_ff - 8'd1;
                  end else begin
                     // Expiry: reload, flag it, and pulse the interrupt if enabled.
                     interval_count_in = reload_value_ff;
                     expired_flag_in   = 1'b1;
                     rsp_irq_in        = irq_enable_ff;
                  end
               end
            end
         end

         default: begin
            // Idle transaction: nothing changes.
            rsp_read_data_in = READ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         out_latch_a_ff     <= '0;
         direction_a_ff     <= '0;
         out_latch_b_ff     <= '0;
         direction_b_ff     <= '0;
         irq_enable_ff      <= 1'b0;
         expired_flag_ff    <= 1'b0;
         timer_running_ff   <= 1'b0;
         interval_count_ff  <= '0;
         reload_value_ff    <= '0;
         prescale_select_ff <= DIV_1;
         prescale_count_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            out_latch_a_ff     <= out_latch_a_in;
            direction_a_ff     <= direction_a_in;
            out_latch_b_ff     <= out_latch_b_in;
            direction_b_ff     <= direction_b_in;
            irq_enable_ff      <= irq_enable_in;
            expired_flag_ff    <= expired_flag_in;
            timer_running_ff   <= timer_running_in;
            interval_count_ff  <= interval_count_in;
            reload_value_ff    <= reload_value_in;
            prescale_select_ff <= prescale_select_in;
            prescale_count_ff  <= prescale_count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff       <= mode_type'(req_mode);
         in_address_ff    <= req_address;
         in_write_data_ff <= req_write_data;
         in_pins_a_ff     <= req_port_a_pins;
         in_pins_b_ff     <= req_port_b_pins;
      end
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_drive_a_ff   <= out_latch_a_in;
         rsp_drive_b_ff   <= out_latch_b_in;
         rsp_strobe_a_ff  <= rsp_strobe_a_in;
         rsp_strobe_b_ff  <= rsp_strobe_b_in;
         rsp_irq_ff       <= rsp_irq_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_port_a_drive  = rsp_drive_a_ff;
   assign rsp_port_b_drive  = rsp_drive_b_ff;
   assign rsp_port_a_strobe = rsp_strobe_a_ff;
   assign rsp_port_b_strobe = rsp_strobe_b_ff;
   assign rsp_irq_pulse     = rsp_irq_ff;

   // An interrupt pulse always comes with the expiry flag set and shows up on
   // the response of the same transaction.
   assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_irq_in) |=> (expired_flag_ff && rsp_irq_pulse && rsp_valid))
      else $error("irq pulse without expiry flag or response");

   // The prescaler never runs past the terminal count of the selected ratio.
   assert property (@(posedge clock) disable iff (reset)
      prescale_count_ff <= prescale_last(prescale_select_ff))
      else $error("prescaler beyond terminal count");

   // A port write strobe is never reported together with read data, nor on both ports at once.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_port_a_strobe || rsp_port_b_strobe)) |->
         (rsp_read_data == READ_IDLE && !(rsp_port_a_strobe && rsp_port_b_strobe)))
      else $error("strobe on a read response");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Block-level bench for the two-port I/O and interval timer.
//
// Every request transaction yields exactly one response transaction. A
// scoreboard model of the ports and timer runs alongside the block. Each
// accepted request advances the model, and the response it computes is
// queued. Each accepted response is compared with the oldest queued entry.
// A few rows of the directed table carry their expected response typed in.
// These are values that are plain from the register map: reads after reset,
// idle and stopped-tick transactions, and the first port writes.
module tb_top;
   import riot_pkg::*;

   // One cycle is 12 ns. The limit is far above the slowest legal run, which
   // is about 600 transactions with full gaps and stalls plus the long hold.
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned RANDOM_ITEMS = 380;
   localparam int unsigned QUIET_TAIL = 80;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_drive;
      logic [7:0] port_b_drive;
      logic       port_a_strobe;
      logic       port_b_strobe;
      logic       irq_pulse;
   } riot_rsp_type;

   typedef struct packed {
      mode_type     mode;
      logic [3:0]   addr;
      logic [7:0]   data;
      logic [7:0]   pins_a;
      logic [7:0]   pins_b;
      logic         typed;     // gold holds the expected response
      riot_rsp_type gold;
   } stim_type;

   localparam riot_rsp_type NO_GOLD = '0;

   // Directed table. Timer addresses are built as {irq enable, timer space,
   // prescale select}.
   localparam int DIRECTED_ROWS = 26;
   localparam stim_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // Reads straight after reset: pins show through, timer and flag at zero.
      '{MODE_READ,  {1'b0, SEL_PORT_A}, 8'h00, 8'hA5, 8'h5A, 1'b1,
        '{8'hA5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  {1'b1, SEL_PORT_B}, 8'h00, 8'h00, 8'h5A, 1'b1,
        '{8'h5A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  {1'b0, SEL_STATUS}, 8'h00, 8'hFF, 8'hFF, 1'b1,
        '{STATUS_CLEAR, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      '{MODE_READ,  {1'b0, SEL_TIMER_0}, 8'h00, 8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      // A tick while the timer is stopped, then the unused idle mode.
      '{MODE_TICK,  {1'b0, SEL_PORT_A}, 8'h00, 8'h00, 8'h00, 1'b1,
        '{READ_IDLE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      '{MODE_IDLE,  {1'b1, SEL_STATUS}, 8'hFF, 8'hFF, 8'hFF, 1'b1,
        '{READ_IDLE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      // Port A all outputs, latch driven to both extremes, once via a mirror.
      '{MODE_WRITE, {1'b0, SEL_DDR_A}, 8'hFF, 8'h00, 8'h00, 1'b1,
        '{READ_IDLE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}},
      '{MODE_WRITE, {1'b0, SEL_PORT_A}, 8'h00, 8'h00, 8'h00, 1'b1,
        '{READ_IDLE, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0}},
      '{MODE_WRITE, {1'b1, SEL_PORT_A}, 8'hFF, 8'h00, 8'h00, 1'b1,
        '{READ_IDLE, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0}},
      // Mixed directions: the read merges pins and latch bit by bit.
      '{MODE_READ,  {1'b0, SEL_PORT_A}, 8'h00, 8'h00, 8'hFF, 1'b0, NO_GOLD},
      '{MODE_WRITE, {1'b0, SEL_DDR_A}, 8'h0F, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b0, SEL_PORT_A}, 8'h00, 8'hC3, 8'h3C, 1'b0, NO_GOLD},
      '{MODE_WRITE, {1'b0, SEL_DDR_B}, 8'hF0, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_WRITE, {1'b1, SEL_PORT_B}, 8'hFF, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b1, SEL_DDR_B}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b0, SEL_PORT_B}, 8'h00, 8'hFF, 8'h0F, 1'b0, NO_GOLD},
      // Timer at count zero, divide by one, interrupt on: every tick expires.
      '{MODE_WRITE, {1'b1, 1'b1, DIV_1}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_TICK,  {1'b0, SEL_PORT_A}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_TICK,  {1'b0, SEL_PORT_A}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      // The status read returns the flag and clears it; the second sees zero.
      '{MODE_READ,  {1'b1, SEL_STATUS}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b1, SEL_STATUS}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      // Restart divide by eight with interrupts off; a timer read turns them on.
      '{MODE_WRITE, {1'b0, 1'b1, DIV_8}, 8'h02, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b1, SEL_TIMER_2}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_WRITE, {1'b1, 1'b1, DIV_1024}, 8'hFF, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_TICK,  {1'b1, SEL_STATUS}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD},
      '{MODE_READ,  {1'b0, SEL_STATUS}, 8'h00, 8'h00, 8'h00, 1'b0, NO_GOLD}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = 2'd0;
   logic [3:0] req_address = 4'd0;
   logic [7:0] req_write_data = 8'd0;
   logic [7:0] req_port_a_pins = 8'd0;
   logic [7:0] req_port_b_pins = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_port_a_drive;
   logic [7:0] rsp_port_b_drive;
   logic       rsp_port_a_strobe;
   logic       rsp_port_b_strobe;
   logic       rsp_irq_pulse;

   riot_ports_and_interval_timer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .req_port_a_pins   (req_port_a_pins),
      .req_port_b_pins   (req_port_b_pins),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_port_a_drive  (rsp_port_a_drive),
      .rsp_port_b_drive  (rsp_port_b_drive),
      .rsp_port_a_strobe (rsp_port_a_strobe),
      .rsp_port_b_strobe (rsp_port_b_strobe),
      .rsp_irq_pulse     (rsp_irq_pulse)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stim_type     stim_q[$];
   riot_rsp_type awaited_rsp[$];
   int unsigned  n_accepted = 0;
   int unsigned  err_count = 0;
   int unsigned  cycle_count = 0;
   logic         quiet = 1'b0;    // set for the tail of the run: no idling at all

   // Scoreboard copy of the block state. Everything clears at reset, and
   // reset happens only once, so the initial values serve as the reset.
   logic [7:0]            sb_latch_a = '0;
   logic [7:0]            sb_dir_a = '0;
   logic [7:0]            sb_latch_b = '0;
   logic [7:0]            sb_dir_b = '0;
   logic                  sb_irq_en = 1'b0;
   logic                  sb_expired = 1'b0;
   logic                  sb_running = 1'b0;
   logic [7:0]            sb_count = '0;
   logic [7:0]            sb_reload = '0;
   prescale_type          sb_div = DIV_1;
   logic [PRESCALE_W-1:0] sb_prescale = '0;

   // Applies one request to the scoreboard state and returns the response
   // that the block must produce for it.
   function automatic riot_rsp_type riot_response(input stim_type it);
      riot_rsp_type r;
      logic [2:0]   sel;
      int unsigned  ratio;
      r = '{READ_IDLE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0};
      sel = it.addr[2:0];
      case (it.mode)
         MODE_READ: begin
            case (sel)
               SEL_PORT_A: r.read_data = (it.pins_a & ~sb_dir_a) | (sb_latch_a & sb_dir_a);
               SEL_DDR_A:  r.read_data = sb_dir_a;
               SEL_PORT_B: r.read_data = (it.pins_b & ~sb_dir_b) | (sb_latch_b & sb_dir_b);
               SEL_DDR_B:  r.read_data = sb_dir_b;
               SEL_STATUS: begin
                  r.read_data = sb_expired ? STATUS_FLAG : STATUS_CLEAR;
                  sb_expired = 1'b0;
                  sb_irq_en = it.addr[IRQ_EN_BIT];
               end
               default: begin
                  // Any of the three timer count offsets.
                  r.read_data = sb_count;
                  sb_irq_en = it.addr[IRQ_EN_BIT];
               end
            endcase
         end
         MODE_WRITE: begin
            case (sel)
               SEL_PORT_A: begin
                  sb_latch_a = it.data;
                  r.port_a_strobe = 1'b1;
               end
               SEL_DDR_A: sb_dir_a = it.data;
               SEL_PORT_B: begin
                  sb_latch_b = it.data;
                  r.port_b_strobe = 1'b1;
               end
               SEL_DDR_B: sb_dir_b = it.data;
               default: begin
                  // Timer start: load the count and restart the prescaler.
                  sb_expired = 1'b0;
                  sb_irq_en = it.addr[IRQ_EN_BIT];
                  sb_reload = it.data;
                  sb_count = it.data;
                  sb_div = prescale_type'(sel[1:0]);
                  sb_prescale = '0;
                  sb_running = 1'b1;
               end
            endcase
         end
         MODE_TICK: begin
            if (sb_running) begin
               case (sb_div)
                  DIV_8:    ratio = 8;
                  DIV_64:   ratio = 64;
                  DIV_1024: ratio = 1024;
                  default:  ratio = 1;
               endcase
               if (int'(sb_prescale) + 1 < ratio) begin
                  sb_prescale = sb_prescale + 1'b1;
               end else begin
                  sb_prescale = '0;
                  if (sb_count != 8'd0) begin
                     sb_count = sb_count - 8'd1;
                  end else begin
                     // Expiry: reload, raise the flag, pulse only if enabled.
                     sb_count = sb_reload;
                     sb_expired = 1'b1;
                     r.irq_pulse = sb_irq_en;
                  end
               end
            end
         end
         default: ;
      endcase
      r.port_a_drive = sb_latch_a;
      r.port_b_drive = sb_latch_b;
      return r;
   endfunction

   // Queues one request with random pin levels; pins matter only on port
   // reads, but randomizing them everywhere checks that nothing else sees them.
   task automatic push_item(input mode_type m, input logic [3:0] a, input logic [7:0] d);
      stim_type s;
      s = '{m, a, d, 8'($urandom), 8'($urandom), 1'b0, NO_GOLD};
      stim_q.push_back(s);
   endtask

   // Picks a prescale ratio; mostly short ones so that expiries are frequent.
   function automatic prescale_type pick_prescale();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k < 5)
         return DIV_1;
      else if (k < 8)
         return DIV_8;
      else if (k < 9)
         return DIV_64;
      return DIV_1024;
   endfunction

   task automatic build_stimulus();
      int unsigned base;
      int unsigned n;
      int unsigned kind;
      logic [7:0]  count;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         stim_q.push_back(DIRECTED[i]);

      // One long run first, so the prescaler counts all the way round: divide
      // by 64 with count one expires after 128 ticks.
      push_item(MODE_WRITE, {1'($urandom), 1'b1, DIV_64}, 8'h01);
      for (int i = 0; i < 132; i++)
         push_item(MODE_TICK, 4'($urandom), 8'($urandom));
      push_item(MODE_READ, {1'($urandom), SEL_STATUS}, 8'($urandom));

      // Random part: mostly timer sequences (start, then ticks mixed with
      // count and status reads), with port traffic and some plain noise.
      base = stim_q.size();
      while (stim_q.size() - base < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            count = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
            push_item(MODE_WRITE, {1'($urandom), 1'b1, pick_prescale()}, count);
            n = $urandom_range(4, 40);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 9))
                  0: push_item(MODE_READ, {1'($urandom), SEL_STATUS}, 8'($urandom));
                  1: push_item(MODE_READ, {1'($urandom), 1'b1, 2'($urandom)}, 8'($urandom));
                  default: push_item(MODE_TICK, 4'($urandom), 8'($urandom));
               endcase
            end
         end else if (kind < 8) begin
            n = $urandom_range(3, 12);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 1) == 0)
                  push_item(MODE_WRITE, {1'($urandom), 1'b0, 2'($urandom)}, 8'($urandom));
               else
                  push_item(MODE_READ, {1'($urandom), 1'b0, 2'($urandom)}, 8'($urandom));
            end
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               push_item(mode_type'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic log_mismatch(input string what, input riot_rsp_type want,
                               input riot_rsp_type got);
      err_count++;
      if (err_count <= 10) begin
         $display("%s: expected rd=%h pa=%h pb=%h sa=%b sb=%b irq=%b",
                  what, want.read_data, want.port_a_drive, want.port_b_drive,
                  want.port_a_strobe, want.port_b_strobe, want.irq_pulse);
         $display("   got rd=%h pa=%h pb=%h sa=%b sb=%b irq=%b",
                  got.read_data, got.port_a_drive, got.port_b_drive,
                  got.port_a_strobe, got.port_b_strobe, got.irq_pulse);
      end
   endtask

   // Request side monitor. All bench inputs change by nonblocking assignment
   // at the rising edge, so the values read here are the ones the block
   // sampled at this edge. The typed-in response, where the row has one,
   // replaces the model's; the model still runs so its state stays in step.
   always @(posedge clock) begin : req_monitor
      stim_type     seen;
      riot_rsp_type calc;
      if (!reset && req_valid && req_ready) begin
         seen = stim_q[n_accepted];
         seen.mode = mode_type'(req_mode);
         seen.addr = req_address;
         seen.data = req_write_data;
         seen.pins_a = req_port_a_pins;
         seen.pins_b = req_port_b_pins;
         calc = riot_response(seen);
         awaited_rsp.push_back(seen.typed ? seen.gold : calc);
         n_accepted++;
      end
   end

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      riot_rsp_type got;
      riot_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_read_data, rsp_port_a_drive, rsp_port_b_drive,
                 rsp_port_a_strobe, rsp_port_b_strobe, rsp_irq_pulse};
         if (awaited_rsp.size() == 0) begin
            log_mismatch("response with none outstanding", NO_GOLD, got);
         end else begin
            want = awaited_rsp.pop_front();
            if (got !== want)
               log_mismatch("response mismatch", want, got);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL riot_ports_and_interval_timer");
         $finish;
      end
   end

   // Response side. Ready toggles in random stretches and stall bursts. Once,
   // about 150 transactions in, it holds off while the sender keeps offering,
   // so that the block fills and drops req_ready. In the quiet tail, ready
   // stays high.
   initial begin : rsp_side
      logic held_off;
      held_off = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (!held_off && n_accepted >= 150) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            held_off = 1'b1;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Main sequence: reset, drive every queued transaction, then drain.
   initial begin : req_side
      logic gaps_on;
      gaps_on = 1'b0;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < stim_q.size(); i++) begin
         // Idling is switched on or off at random every 40 transactions, so there are
         // stretches with back-to-back transactions as well as gappy ones.
         if (i % 40 == 0)
            gaps_on = ($urandom_range(0, 2) != 0);
         if (i + QUIET_TAIL >= stim_q.size())
            quiet = 1'b1;
         if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_mode <= stim_q[i].mode;
         req_address <= stim_q[i].addr;
         req_write_data <= stim_q[i].data;
         req_port_a_pins <= stim_q[i].pins_a;
         req_port_b_pins <= stim_q[i].pins_b;
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
      end
      req_valid <= 1'b0;

      // Let the monitor record the last transaction, wait for every response,
      // then keep watching the two-stage pipe for any stray response.
      @(posedge clock);
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (err_count == 0 && awaited_rsp.size() == 0) begin
         $display("PASS riot_ports_and_interval_timer");
      end else begin
         $display("FAIL riot_ports_and_interval_timer");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/riot_pkg.sv
rtl/riot_ports_and_interval_timer.sv
bench/tb_top.sv
